@@ rtl/sgd_pkg.sv @@
// shared constants and register indexes for the signed gadget decomposition unit
// no dependencies
`default_nettype none

package sgd_pkg;

  // default sizing
  localparam int unsigned MAX_DIGITS_DEF  = 8;
  localparam int unsigned COEFF_WIDTH_DEF = 32;

  // field widths
  localparam int unsigned DIGIT_W   = 30;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned BASE_W    = 5;
  localparam int unsigned BASE_MAX  = 30;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BITS   = 2'd1;

  // reset values
  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd3;
  localparam logic [BASE_W-1:0]  BASE_BITS_RST   = 5'd10;

endpackage

`default_nettype wire

@@ rtl/sgd_digit_slice.sv @@
// one decomposition step: extracts the centred digit at a given weight shift
// and subtracts it back from the running value; uses sgd_pkg
`default_nettype none

module sgd_digit_slice #(
  parameter int unsigned CoeffWidth = sgd_pkg::COEFF_WIDTH_DEF,
  parameter int unsigned ShiftW     = 8
) (
  input  wire logic        [CoeffWidth-1:0]      value_i,
  input  wire logic signed [ShiftW-1:0]          shift_i,
  input  wire logic        [sgd_pkg::BASE_W-1:0] base_bits_i,
  output logic signed      [sgd_pkg::DIGIT_W-1:0] digit_o,
  output logic             [CoeffWidth-1:0]      value_o
);
  import sgd_pkg::*;

  // wide enough for a sign-extended digit and for the coefficient
  localparam int unsigned DW = (CoeffWidth > DIGIT_W) ? CoeffWidth : DIGIT_W;

  logic                       neg;
  logic [ShiftW-1:0]          amt;
  logic [DIGIT_W-1:0]         window;
  logic [DIGIT_W:0]           mask_ext;
  logic [DIGIT_W-1:0]         bmask;
  logic [DIGIT_W-1:0]         low;
  logic [BASE_W-1:0]          sign_idx;
  logic signed [DW-1:0]       digit_w;
  logic signed [DW-1:0]       back_w;

  // magnitude of the weight shift
  assign neg = shift_i[ShiftW-1];
  assign amt = neg ? ShiftW'(-shift_i) : ShiftW'(shift_i);

  // bring the digit window down to bit zero
  always_comb begin
    if (neg) begin
      window = DIGIT_W'(value_i) << amt;
    end else begin
      window = DIGIT_W'(value_i >> amt);
    end
  end

  // remainder modulo the base, then centred around zero
  assign mask_ext = ((DIGIT_W + 1)'(1) << base_bits_i) - (DIGIT_W + 1)'(1);
  assign bmask    = mask_ext[DIGIT_W-1:0];
  assign low      = window & bmask;
  assign sign_idx = base_bits_i - BASE_W'(1);
  assign digit_o  = low[sign_idx] ? signed'(low | ~bmask) : signed'(low);

  // subtract the digit back at its weight, carry moves up
  assign digit_w = DW'(digit_o);
  always_comb begin
    if (neg) begin
      back_w = digit_w >>> amt;
    end else begin
      back_w = digit_w << amt;
    end
  end

  assign value_o = value_i - CoeffWidth'(back_w);

endmodule

`default_nettype wire

@@ rtl/signed_gadget_decomposition_unit.sv @@
// top level of the signed gadget decomposition unit: config registers,
// coefficient register with rounding, digit sequencing and result register
// depends on sgd_pkg and sgd_digit_slice
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------
//   in       | in        | in_valid_i / in_stall_o | coefficient_i
//   out      | out       | out_valid_o/ out_stall_i| digit_o, digit_position_o, last_o
//   cfg      | in        | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// a coefficient occupies the digit stage for digit_count digits, one digit per
// cycle while the output is not stalled, set by the single shared digit slice; the
// next coefficient is taken in the cycle its predecessor's last digit moves to
// the result register; a first digit passes the digit stage and result registers.
// reset clears the handshake state and loads digit_count=3, base_bits=10.
// a stall on the output holds the result register and freezes the digit stage.
`default_nettype none

module signed_gadget_decomposition_unit #(
  parameter int unsigned MAX_DIGITS  = sgd_pkg::MAX_DIGITS_DEF,
  parameter int unsigned COEFF_WIDTH = sgd_pkg::COEFF_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // coefficient channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [COEFF_WIDTH-1:0]      coefficient_i,
  // digit channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [sgd_pkg::DIGIT_W-1:0]      digit_o,
  output logic        [sgd_pkg::POS_W-1:0]        digit_position_o,
  output logic                                    last_o,
  // configuration channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sgd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [sgd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sgd_pkg::*;

  localparam int unsigned ShiftW = $clog2(COEFF_WIDTH + BASE_MAX * MAX_DIGITS + 1) + 1;
  localparam int unsigned CntW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PosW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // configuration registers
  logic [COUNT_W-1:0] digit_count_q;
  logic [BASE_W-1:0]  base_bits_q;

  // digit stage
  logic                     busy_q;
  logic [COEFF_WIDTH-1:0]   value_q;
  logic signed [ShiftW-1:0] shift_q;
  logic [PosW-1:0]          pos_q;

  // result register
  logic                       out_valid_q;
  logic signed [DIGIT_W-1:0]  digit_q;
  logic [POS_W-1:0]           pos_out_q;
  logic                       last_q;

  logic [CntW-1:0]          count_eff;
  logic [BASE_W-1:0]        base_eff;
  logic signed [ShiftW-1:0] prod;
  logic signed [ShiftW-1:0] shift_start;
  logic [COEFF_WIDTH-1:0]   half;
  logic [COEFF_WIDTH-1:0]   rounded;
  logic                     out_free;
  logic                     advance;
  logic                     last_step;
  logic                     in_accept;
  logic signed [DIGIT_W-1:0] slice_digit;
  logic [COEFF_WIDTH-1:0]   slice_value;

  // clamp the configuration to its legal range
  always_comb begin
    if (digit_count_q == '0) begin
      count_eff = CntW'(1);
    end else if (32'(digit_count_q) > MAX_DIGITS) begin
      count_eff = CntW'(MAX_DIGITS);
    end else begin
      count_eff = CntW'(digit_count_q);
    end
    if (base_bits_q == '0) begin
      base_eff = BASE_W'(1);
    end else if (32'(base_bits_q) > BASE_MAX) begin
      base_eff = BASE_W'(BASE_MAX);
    end else begin
      base_eff = base_bits_q;
    end
  end

  // weight shift of the finest digit, also the number of dropped bits
  assign prod        = signed'(ShiftW'(base_eff)) * signed'(ShiftW'(count_eff));
  assign shift_start = signed'(ShiftW'(COEFF_WIDTH)) - prod;

  // round to the kept precision when fewer bits are kept than the coefficient has
  always_comb begin
    rounded = coefficient_i;
    half    = '0;
    if (shift_start > signed'(ShiftW'(0))) begin
      half    = COEFF_WIDTH'(1) << (shift_start - signed'(ShiftW'(1)));
      rounded = (coefficient_i + half) & ~((half << 1) - COEFF_WIDTH'(1));
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = busy_q && out_free;
  assign last_step  = advance && (pos_q == '0);
  assign in_stall_o = busy_q && !last_step;
  assign in_accept  = in_valid_i && !in_stall_o;

  sgd_digit_slice #(
    .CoeffWidth (COEFF_WIDTH),
    .ShiftW     (ShiftW)
  ) u_slice (
    .value_i     (value_q),
    .shift_i     (shift_q),
    .base_bits_i (base_eff),
    .digit_o     (slice_digit),
    .value_o     (slice_value)
  );

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DIGIT_COUNT_RST;
      base_bits_q   <= BASE_BITS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIGIT_COUNT: digit_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_BASE_BITS:   base_bits_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // digit stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
    end else if (last_step) begin
      busy_q <= 1'b0;
    end
  end

  // digit stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      value_q <= rounded;
      shift_q <= shift_start;
      pos_q   <= PosW'(count_eff - CntW'(1));
    end else if (advance) begin
      value_q <= slice_value;
      shift_q <= shift_q + signed'(ShiftW'(base_eff));
      pos_q   <= pos_q - PosW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      digit_q   <= slice_digit;
      pos_out_q <= POS_W'(pos_q);
      last_q    <= (pos_q == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign digit_o          = digit_q;
  assign digit_position_o = pos_out_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire
